### sv/can_transfer_segmenter_assert.svh
// Assertion macros for the CAN transfer segmenter checks.
`ifndef CAN_TRANSFER_SEGMENTER_ASSERT_SVH
`define CAN_TRANSFER_SEGMENTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cts check failed");

// Next-cycle implication, disabled during reset.
`define CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cts check failed");

`endif

### sv/cts_pkg.sv
// Package: types and constants of the CAN transfer segmenter.
package cts_pkg;

    localparam int ChunkMax   = 7;
    localparam int ByteW      = 8;
    localparam int IdentW     = 29;
    localparam int LenW       = 4;
    localparam int ChunkW     = ChunkMax * ByteW;
    localparam int FillW      = 3;
    localparam int TidW       = 5;
    localparam int PrioW      = 5;
    localparam int SubjectW   = 16;
    localparam int NodeW      = 7;
    localparam int CfgIndexW  = 2;
    localparam int CfgDataW   = 16;

    localparam logic [PrioW-1:0]    PrioReset    = 5'd16;
    localparam logic [SubjectW-1:0] SubjectReset = 16'd3840;
    localparam logic [NodeW-1:0]    NodeReset    = 7'd125;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_PRIORITY = 2'd0,
        CFG_SUBJECT  = 2'd1,
        CFG_NODE     = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [IdentW-1:0] frame_identifier;
        logic [LenW-1:0]   frame_length;
        logic [ByteW-1:0]  header_byte;
        logic [ChunkW-1:0] chunk_bytes;
    } t_frame;

endpackage

### sv/cts_if.sv
// Channel interfaces: payload byte stream in, CAN frames out.
interface cts_byte_if import cts_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] payload_byte;
    logic             final_byte;

    modport source (output valid, output payload_byte, output final_byte, input ready);
    modport sink   (input valid, input payload_byte, input final_byte, output ready);
endinterface

interface cts_frame_if import cts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IdentW-1:0] frame_identifier;
    logic [LenW-1:0]   frame_length;
    logic [ByteW-1:0]  header_byte;
    logic [ChunkW-1:0] chunk_bytes;

    modport source (output valid, output frame_identifier, output frame_length,
                    output header_byte, output chunk_bytes, input ready);
    modport sink   (input valid, input frame_identifier, input frame_length,
                    input header_byte, input chunk_bytes, output ready);
endinterface

### sv/can_transfer_segmenter.sv
// CAN transfer segmenter: gathers payload bytes into frames with header byte.
// A frame is built as its closing byte is taken and lands in the output register (skid if stalled).
// Throughput: one payload byte per cycle; frames leave through an output
// register backed by a one-entry skid register, so input stalls only when both hold frames.
// Reset: synchronous active-low; clears fill, toggle, transfer id and output valids, sets the
// start flag, and loads the identifier registers with their defaults.
module can_transfer_segmenter import cts_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cts_byte_if.sink             i_byte,
    cts_frame_if.source          o_frame,
    input  logic                 i_cfg_we,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [CfgDataW-1:0]  i_cfg_data
);

    logic [PrioW-1:0]    r_prio;
    logic [SubjectW-1:0] r_subject;
    logic [NodeW-1:0]    r_node;

    logic [ByteW-1:0]    r_store [ChunkMax-1];
    logic [FillW-1:0]    r_fill;
    logic                r_start;
    logic                r_toggle;
    logic [TidW-1:0]     r_tid;

    t_frame              r_out;
    logic                r_out_valid;
    t_frame              r_skid;
    logic                r_skid_valid;

    logic                in_fire;
    logic                out_fire;
    logic [FillW-1:0]    n_fill;
    logic                emit;
    logic                produce;
    logic [ChunkW-1:0]   stored;
    t_frame              n_frame;

    assign in_fire  = i_byte.valid && i_byte.ready;
    assign out_fire = r_out_valid && o_frame.ready;
    assign n_fill   = r_fill + 3'd1;
    assign emit     = i_byte.final_byte || (n_fill == FillW'(ChunkMax));
    assign produce  = in_fire && emit;

    always_comb begin
        stored = '0;
        for (int i = 0; i < ChunkMax - 1; i++) begin
            stored[i*ByteW +: ByteW] = r_store[i];
        end
    end

    always_comb begin
        n_frame.frame_identifier = {r_prio, r_subject, 1'b0, r_node};
        n_frame.frame_length     = LenW'(r_fill) + 4'd2;
        n_frame.header_byte      = {r_start, i_byte.final_byte, r_toggle, r_tid};
        for (int i = 0; i < ChunkMax; i++) begin
            if (FillW'(i) == r_fill) begin
                n_frame.chunk_bytes[i*ByteW +: ByteW] = i_byte.payload_byte;
            end else if (FillW'(i) < r_fill) begin
                n_frame.chunk_bytes[i*ByteW +: ByteW] = stored[i*ByteW +: ByteW];
            end else begin
                n_frame.chunk_bytes[i*ByteW +: ByteW] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio    <= PrioReset;
            r_subject <= SubjectReset;
            r_node    <= NodeReset;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_PRIORITY: r_prio    <= i_cfg_data[PrioW-1:0];
                CFG_SUBJECT:  r_subject <= i_cfg_data[SubjectW-1:0];
                CFG_NODE:     r_node    <= i_cfg_data[NodeW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ChunkMax - 1; i++) begin
            if (in_fire && !emit && r_fill == FillW'(i)) begin
                r_store[i] <= i_byte.payload_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_start  <= 1'b1;
            r_toggle <= 1'b0;
            r_tid    <= '0;
        end else if (in_fire) begin
            if (emit) begin
                r_fill <= '0;
                if (i_byte.final_byte) begin
                    r_start  <= 1'b1;
                    r_toggle <= 1'b0;
                    r_tid    <= r_tid + 5'd1;
                end else begin
                    r_start  <= 1'b0;
                    r_toggle <= !r_toggle;
                end
            end else begin
                r_fill <= n_fill;
            end
        end
    end

    // Output register plus skid: a new frame lands in the skid only when the
    // output register is held by a stalled transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (produce) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (produce) begin
            if (!r_out_valid || out_fire) begin
                r_out <= n_frame;
            end else begin
                r_skid <= n_frame;
            end
        end
    end

    assign i_byte.ready             = !r_skid_valid;
    assign o_frame.valid            = r_out_valid;
    assign o_frame.frame_identifier = r_out.frame_identifier;
    assign o_frame.frame_length     = r_out.frame_length;
    assign o_frame.header_byte      = r_out.header_byte;
    assign o_frame.chunk_bytes      = r_out.chunk_bytes;

endmodule

### sv/cts_checker.sv
// Port-level checks for the CAN transfer segmenter, bound to the top level.
`include "can_transfer_segmenter_assert.svh"

module cts_checker import cts_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [IdentW-1:0] i_frame_identifier,
    input logic [LenW-1:0]   i_frame_length,
    input logic [ByteW-1:0]  i_header_byte,
    input logic [ChunkW-1:0] i_chunk_bytes
);

    // A stalled frame transaction keeps its contents.
    `CTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_frame_identifier) && $stable(i_frame_length)
        && $stable(i_header_byte) && $stable(i_chunk_bytes))

    // Input only stalls while a frame is waiting at the output.
    `CTS_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !i_in_ready, i_out_valid)

    // A short frame can only close a transfer.
    `CTS_ASSERT_NOW(a_short_is_end, i_clk, i_rst_n,
        i_out_valid && i_frame_length != 4'd8, i_header_byte[6])

    // A one-byte chunk leaves the upper octets clear, and identifier bit 7 is zero.
    `CTS_ASSERT_NOW(a_frame_shape, i_clk, i_rst_n,
        i_out_valid && i_frame_length == 4'd2,
        i_chunk_bytes[ChunkW-1:ByteW] == '0 && !i_frame_identifier[7])

endmodule

bind can_transfer_segmenter cts_checker u_cts_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_ready         (i_byte.ready),
    .i_out_valid        (o_frame.valid),
    .i_out_ready        (o_frame.ready),
    .i_frame_identifier (o_frame.frame_identifier),
    .i_frame_length     (o_frame.frame_length),
    .i_header_byte      (o_frame.header_byte),
    .i_chunk_bytes      (o_frame.chunk_bytes)
);

### tb/testbench.sv
// Testbench for can_transfer_segmenter: byte stream in, predicted CAN frames checked out.
`timescale 1ns / 100ps

module testbench;
    import cts_pkg::*;

    localparam int StallLimit   = 2000;
    localparam int SettleCycles = 4;
    localparam int RandomPhases = 8;
    localparam int PhaseBytes   = 250;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    t_cfg_index          cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    cts_byte_if  payload_ch ();
    cts_frame_if frame_ch ();

    can_transfer_segmenter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (payload_ch),
        .o_frame     (frame_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // predictor state
    logic [PrioW-1:0]    cur_priority;
    logic [SubjectW-1:0] cur_subject;
    logic [NodeW-1:0]    cur_node;
    logic [ByteW-1:0]    gather_buf [ChunkMax];
    int                  gather_fill;
    logic                start_pending;
    logic                toggle;
    logic [TidW-1:0]     tid;
    t_frame              pending_frames [$];

    int  fail_count;
    int  frames_checked;
    int  bytes_accepted;
    int  transfers_sent;
    int  config_writes;
    int  stall_cycles;
    int  ready_hold;
    bit  no_idle;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic void segmenter_reset();
        cur_priority  = PrioReset;
        cur_subject   = SubjectReset;
        cur_node      = NodeReset;
        gather_fill   = 0;
        start_pending = 1'b1;
        toggle        = 1'b0;
        tid           = '0;
    endfunction

    function automatic void predict_segment(input logic [ByteW-1:0] data, input logic last);
        t_frame            frm;
        logic [ChunkW-1:0] packed_chunk;
        int                k;
        gather_buf[gather_fill] = data;
        gather_fill++;
        if (gather_fill < ChunkMax && !last)
            return;
        packed_chunk = '0;
        for (k = 0; k < gather_fill; k++)
            packed_chunk[k*ByteW +: ByteW] = gather_buf[k];
        frm.frame_identifier = {cur_priority, cur_subject, 1'b0, cur_node};
        frm.frame_length     = LenW'(gather_fill + 1);
        frm.header_byte      = {start_pending, last, toggle, tid};
        frm.chunk_bytes      = packed_chunk;
        pending_frames.push_back(frm);
        gather_fill = 0;
        if (last) begin
            start_pending = 1'b1;
            toggle        = 1'b0;
            tid           = tid + 1'b1;
        end else begin
            start_pending = 1'b0;
            toggle        = ~toggle;
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_val,
                                        input logic [63:0] act_val);
        if (act_val !== exp_val) begin
            fail_count++;
            if (fail_count <= 10)
                $display("MISMATCH %s: expected %0h, got %0h (frame %0d)",
                         name, exp_val, act_val, frames_checked);
        end
    endfunction

    // predict on accepted bytes, compare accepted frames
    always @(posedge i_clk) begin
        t_frame exp_frm;
        if (i_rst_n) begin
            if (payload_ch.valid && payload_ch.ready) begin
                bytes_accepted++;
                predict_segment(payload_ch.payload_byte, payload_ch.final_byte);
            end
            if (frame_ch.valid && frame_ch.ready) begin
                if (pending_frames.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("MISMATCH unexpected frame: id %0h header %0h",
                                 frame_ch.frame_identifier, frame_ch.header_byte);
                end else begin
                    exp_frm = pending_frames.pop_front();
                    check_field("frame_identifier", 64'(exp_frm.frame_identifier),
                                64'(frame_ch.frame_identifier));
                    check_field("frame_length", 64'(exp_frm.frame_length),
                                64'(frame_ch.frame_length));
                    check_field("header_byte", 64'(exp_frm.header_byte),
                                64'(frame_ch.header_byte));
                    check_field("chunk_bytes", 64'(exp_frm.chunk_bytes),
                                64'(frame_ch.chunk_bytes));
                    frames_checked++;
                end
            end
        end
    end

    // frame sink back-pressure
    always @(negedge i_clk) begin
        int r;
        if (!i_rst_n) begin
            frame_ch.ready <= 1'b0;
            ready_hold = 0;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else if (no_idle) begin
            frame_ch.ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                frame_ch.ready <= 1'b1;
                ready_hold = $urandom_range(0, 20);
            end else if (r < 92) begin
                frame_ch.ready <= 1'b0;
                ready_hold = $urandom_range(0, 2);
            end else begin
                frame_ch.ready <= 1'b0;
                ready_hold = $urandom_range(10, 30);
            end
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < StallLimit) begin
            @(posedge i_clk);
            if (!i_rst_n || (payload_ch.valid && payload_ch.ready)
                    || (frame_ch.valid && frame_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Timeout: no transaction for %0d cycles", StallLimit);
        $display("Test completed with failures");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return ChunkMax * $urandom_range(1, 3);
        if (r < 70)
            return $urandom_range(1, 14);
        if (r < 95)
            return $urandom_range(15, 30);
        return $urandom_range(31, 60);
    endfunction

    task automatic send_byte(input logic [ByteW-1:0] data, input logic last);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            payload_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        payload_ch.valid        <= 1'b1;
        payload_ch.payload_byte <= data;
        payload_ch.final_byte   <= last;
        do @(posedge i_clk); while (!payload_ch.ready);
    endtask

    task automatic send_transfer(input int len);
        int k;
        for (k = 0; k < len; k++)
            send_byte(ByteW'($urandom_range(0, 255)), k == len - 1);
        transfers_sent++;
    endtask

    task automatic drain_and_settle();
        @(negedge i_clk);
        payload_ch.valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [CfgDataW-1:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PRIORITY: cur_priority = value[PrioW-1:0];
            CFG_SUBJECT:  cur_subject  = value[SubjectW-1:0];
            CFG_NODE:     cur_node     = value[NodeW-1:0];
            default: ;
        endcase
        config_writes++;
    endtask

    // pick min, max or random for each register
    task automatic write_random_config();
        int r;
        r = $urandom_range(0, 3);
        write_register(CFG_PRIORITY, (r == 0) ? '0 :
                       (r == 1) ? CfgDataW'(31) : CfgDataW'($urandom_range(0, 31)));
        r = $urandom_range(0, 3);
        write_register(CFG_SUBJECT, (r == 0) ? '0 :
                       (r == 1) ? CfgDataW'(16'hFFFF) : CfgDataW'($urandom_range(0, 65535)));
        r = $urandom_range(0, 3);
        write_register(CFG_NODE, (r == 0) ? '0 :
                       (r == 1) ? CfgDataW'(127) : CfgDataW'($urandom_range(0, 127)));
    endtask

    // reset values; single frame, full chunk ending the transfer, full chunk then tail
    task automatic test_default_config();
        int k;
        send_byte(8'h00, 1'b1);
        for (k = 0; k < ChunkMax; k++)
            send_byte(ByteW'(8'h11 * (k + 1)), k == ChunkMax - 1);
        for (k = 0; k < ChunkMax + 1; k++)
            send_byte((k % 2) ? 8'hFF : 8'h00, k == ChunkMax);
        transfers_sent += 3;
        drain_and_settle();
    endtask

    task automatic test_config_extremes();
        write_register(CFG_PRIORITY, CfgDataW'(31));
        write_register(CFG_SUBJECT, 16'hFFFF);
        write_register(CFG_NODE, CfgDataW'(127));
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        transfers_sent++;
        drain_and_settle();
        write_register(CFG_PRIORITY, '0);
        write_register(CFG_SUBJECT, '0);
        write_register(CFG_NODE, '0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b1);
        transfers_sent++;
        drain_and_settle();
    endtask

    task automatic test_random_transfers();
        int phase;
        int budget;
        int len;
        for (phase = 0; phase < RandomPhases; phase++) begin
            write_random_config();
            no_idle = (phase == 3);
            budget  = PhaseBytes;
            while (budget > 0) begin
                len = pick_length();
                send_transfer(len);
                budget -= len;
            end
            drain_and_settle();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n                 = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = CFG_PRIORITY;
        cfg_data                = '0;
        payload_ch.valid        = 1'b0;
        payload_ch.payload_byte = '0;
        payload_ch.final_byte   = 1'b0;
        frame_ch.ready          = 1'b0;
        no_idle                 = 1'b0;
        fail_count              = 0;
        frames_checked          = 0;
        bytes_accepted          = 0;
        transfers_sent          = 0;
        config_writes           = 0;
        ready_hold              = 0;
        segmenter_reset();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_config();
        test_config_extremes();
        test_random_transfers();

        if (pending_frames.size() != 0) begin
            $display("Missing %0d expected frames", pending_frames.size());
            fail_count += pending_frames.size();
        end
        $display("Sent %0d transfers (%0d payload bytes), checked %0d frames",
                 transfers_sent, bytes_accepted, frames_checked);
        $display("Register writes: %0d, failures: %0d", config_writes, fail_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
